// ===== design/cbod_pkg.sv =====
// Shared types and constants for the chained block obfuscation decrypter.
`default_nettype none
package cbod_pkg;

  localparam int unsigned BLOCK_W = 64;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned INDEX_W = 2;

  // Configuration register indexes
  localparam logic [INDEX_W-1:0] REG_KEY_A = 2'd0;
  localparam logic [INDEX_W-1:0] REG_KEY_B = 2'd1;
  localparam logic [INDEX_W-1:0] REG_KEY_C = 2'd2;
  localparam logic [INDEX_W-1:0] REG_MODE  = 2'd3;

  // Mode bits: bit 1 selects pass-through, bit 0 selects the second round
  localparam int unsigned MODE_FULL_BIT = 0;
  localparam int unsigned MODE_PASS_BIT = 1;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd1;

  // Obfuscation round constants
  localparam logic [7:0] MUL_BYTE0 = 8'd63;
  localparam logic [7:0] MUL_BYTE1 = 8'd17;
  localparam logic [7:0] ADD_CONST = 8'd51;

  // Control from the sequencer to the datapath
  typedef struct packed {
    logic in_ready;
    logic mid_load;
    logic fold1;
    logic fold2;
    logic out_valid;
  } ctl_t;

endpackage
`default_nettype wire

// ===== design/cbod_obf.sv =====
// Shared obfuscation round unit, split in two phases around a register.
`default_nettype none
module cbod_obf (
  input  wire logic                          clk,
  input  wire logic                          mid_load,
  input  wire logic [cbod_pkg::BLOCK_W-1:0]  work,
  output logic      [cbod_pkg::BLOCK_W-1:0]  mask
);

  logic [7:0]  d0, d1, d2, d3;
  logic [15:0] prod0, prod1, prod2;
  logic [7:0]  a_val, b_val, c_val, d_val, e_val;
  logic [7:0]  b_q, d_q, e_q, d3_q;
  logic [7:0]  f_val, g_val, h_val, i_val;

  assign d0 = work[7:0];
  assign d1 = work[15:8];
  assign d2 = work[23:16];
  assign d3 = work[31:24];

  // Phase one: constant products and the sums that feed the last product
  assign prod0 = {8'd0, d0} * {8'd0, cbod_pkg::MUL_BYTE0};
  assign prod1 = {8'd0, d1} * {8'd0, cbod_pkg::MUL_BYTE1};
  assign a_val = prod0[7:0];
  assign b_val = a_val + d3;
  assign c_val = prod1[7:0];
  assign d_val = c_val + d2;
  assign e_val = d_val + b_val;

  always_ff @(posedge clk) begin
    if (mid_load) begin
      b_q  <= b_val;
      d_q  <= d_val;
      e_q  <= e_val;
      d3_q <= d3;
    end
  end

  // Phase two: data-dependent product and the mask bytes
  assign prod2 = {8'd0, e_q} * {8'd0, d3_q};
  assign f_val = prod2[7:0];
  assign g_val = f_val + b_q + cbod_pkg::ADD_CONST;
  assign h_val = b_q ^ d_q;
  assign i_val = g_val ^ e_q;

  assign mask = {g_val, i_val, d_q, h_val, 32'd0};

endmodule
`default_nettype wire

// ===== design/cbod_ctrl.sv =====
// Sequencer that steps the shared round unit through one or two rounds, or skips it in pass-through mode.
`default_nettype none
module cbod_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic out_ready,
  input  wire logic mode_pass,
  input  wire logic mode_full,
  output cbod_pkg::ctl_t ctl
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_A1   = 6'b000010,
    S_B1   = 6'b000100,
    S_A2   = 6'b001000,
    S_B2   = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = mode_pass ? S_OUT : S_A1;
        end
      end
      S_A1: state_next = S_B1;
      S_B1: state_next = mode_full ? S_A2 : S_OUT;
      S_A2: state_next = S_B2;
      S_B2: state_next = S_OUT;
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign ctl.in_ready  = (state == S_IDLE);
  assign ctl.mid_load  = (state == S_A1) || (state == S_A2);
  assign ctl.fold1     = (state == S_B1);
  assign ctl.fold2     = (state == S_B2);
  assign ctl.out_valid = (state == S_OUT);

endmodule
`default_nettype wire

// ===== design/chained_block_obfuscation_decrypt.sv =====
// Top level of the chained block obfuscation decrypter.
//
// Usage: cipher blocks enter on the s_axis channel (tdata = cipher_block,
// tuser = first_of_file) and plain blocks leave on m_axis (tdata =
// plain_block), one plain block per cipher block, in order. Keys and mode
// are written through cfg_we/cfg_index/cfg_data while the block is idle.
//
// Operation: one item at a time. After the accepting edge, pass-through
// mode goes straight to the output state, single-round mode first runs one
// obfuscation round and full mode runs two. Each round uses the one shared
// round unit, first for the constant products, then for the data-dependent
// product, and the result is then offered until the output handshake.
//
// Reset clears the keys and the previous-block chain register and sets
// full mode. When the receiver stalls, the result holds on m_axis_tdata and
// no new item is taken until it is accepted.
`default_nettype none
module chained_block_obfuscation_decrypt (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic [cbod_pkg::BLOCK_W-1:0]          s_axis_tdata,  // cipher_block
  input  wire logic                                  s_axis_tuser,  // first_of_file
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic      [cbod_pkg::BLOCK_W-1:0]          m_axis_tdata,  // plain_block
  input  wire logic                                  cfg_we,
  input  wire logic [cbod_pkg::INDEX_W-1:0]          cfg_index,
  input  wire logic [cbod_pkg::BLOCK_W-1:0]          cfg_data
);

  logic [cbod_pkg::BLOCK_W-1:0] key_a, key_b, key_c;
  logic [cbod_pkg::MODE_W-1:0]  cipher_mode;
  logic [cbod_pkg::MODE_W-1:0]  mode_q;
  logic [cbod_pkg::BLOCK_W-1:0] prior_cipher;
  logic [cbod_pkg::BLOCK_W-1:0] work;
  logic [cbod_pkg::BLOCK_W-1:0] chain;
  logic [cbod_pkg::BLOCK_W-1:0] out_data;
  logic [cbod_pkg::BLOCK_W-1:0] mask;
  logic [cbod_pkg::BLOCK_W-1:0] round_out;
  logic [cbod_pkg::BLOCK_W-1:0] swapped;
  logic                         in_fire;
  cbod_pkg::ctl_t               ctl;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_a       <= '0;
      key_b       <= '0;
      key_c       <= '0;
      cipher_mode <= cbod_pkg::MODE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbod_pkg::REG_KEY_A: key_a       <= cfg_data;
        cbod_pkg::REG_KEY_B: key_b       <= cfg_data;
        cbod_pkg::REG_KEY_C: key_c       <= cfg_data;
        cbod_pkg::REG_MODE:  cipher_mode <= cfg_data[cbod_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Previous cipher block: loaded on every accepted item, whatever the mode
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_cipher <= '0;
    end else if (in_fire) begin
      prior_cipher <= s_axis_tdata;
    end
  end

  cbod_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .out_ready (m_axis_tready),
    .mode_pass (cipher_mode[cbod_pkg::MODE_PASS_BIT]),
    .mode_full (mode_q[cbod_pkg::MODE_FULL_BIT]),
    .ctl       (ctl)
  );

  cbod_obf u_obf (
    .clk      (clk),
    .mid_load (ctl.mid_load),
    .work     (work),
    .mask     (mask)
  );

  assign round_out = work ^ mask;
  assign swapped   = {round_out[31:0], round_out[63:32]};

  // Datapath: the work register carries the block between rounds
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_q <= cipher_mode;
      work   <= s_axis_tdata ^ key_a;
      chain  <= s_axis_tuser ? '0 : prior_cipher;
      // Pass-through: result is the cipher block itself, no chaining
      if (cipher_mode[cbod_pkg::MODE_PASS_BIT]) begin
        out_data <= s_axis_tdata;
      end
    end else if (ctl.fold1) begin
      work     <= swapped ^ key_b;
      out_data <= swapped ^ chain;
    end else if (ctl.fold2) begin
      out_data <= round_out ^ key_c ^ chain;
    end
  end

  assign s_axis_tready = ctl.in_ready;
  assign m_axis_tvalid = ctl.out_valid;
  assign m_axis_tdata  = out_data;

  // One item in flight: never take input while a result is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while output valid");

  // Pass-through returns the accepted block on the next cycle
  a_pass_latency: assert property (@(posedge clk) disable iff (rst)
    (in_fire && cipher_mode[cbod_pkg::MODE_PASS_BIT])
      |=> (m_axis_tvalid && m_axis_tdata == $past(s_axis_tdata)))
    else $error("pass-through result wrong or late");

  // Single-round mode offers its result once states S_A1 and S_B1 follow acceptance
  a_single_latency: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !cipher_mode[cbod_pkg::MODE_PASS_BIT]
             && !cipher_mode[cbod_pkg::MODE_FULL_BIT])
      |-> ##3 m_axis_tvalid)
    else $error("single-round result late");

endmodule
`default_nettype wire
